@@ rtl/prrs_pkg.sv @@
// ----------------------------------------------------------------------------
// prrs_pkg
// Shared types and constants of the palette remap row scaler.
// ----------------------------------------------------------------------------
package prrs_pkg;

    // Default parameter values
    localparam int TOP_START_DEF    = 16;
    localparam int BOTTOM_START_DEF = 96;
    localparam int MAX_WIDTH_DEF    = 512;

    // Field widths
    localparam int IDX_W   = 8;
    localparam int COLOR_W = 32;
    localparam int COL_W   = 10;
    localparam int OCOL_W  = 9;
    localparam int POS_W   = 26;
    localparam int STEP_W  = 24;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 24;
    localparam int PAL_DEPTH = 256;

    // Request commands
    localparam logic CMD_PAL_WRITE = 1'b0;
    localparam logic CMD_TEXEL     = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] REG_TOP_COLOR    = 3'd0;
    localparam logic [CFG_AW-1:0] REG_BOTTOM_COLOR = 3'd1;
    localparam logic [CFG_AW-1:0] REG_SWAP         = 3'd2;
    localparam logic [CFG_AW-1:0] REG_DEST_WIDTH   = 3'd3;
    localparam logic [CFG_AW-1:0] REG_FRAC_STEP    = 3'd4;

    // Remap constants
    localparam logic [3:0] CHOICE_MAX  = 4'd13;
    localparam logic [3:0] CHOICE_SWAP = 4'd4;
    localparam logic [7:0] RANGE_FLIP  = 8'd128;
    localparam int         RANGE_LEN   = 16;

    // Pixel constants
    localparam logic [IDX_W-1:0]   FULLBRIGHT = 8'd224;
    localparam logic [COLOR_W-1:0] GLOW_MASK  = 32'h00FF_FFFF;
    localparam logic [STEP_W-1:0]  MIN_STEP   = 24'd8192;
    localparam logic [COL_W-1:0]   COL_MAX    = 10'd1023;
    localparam logic [3:0]         MAX_BURST  = 4'd8;

    // Remap settings handed to the remap unit
    typedef struct packed {
        logic [3:0] top_color;
        logic [3:0] bottom_color;
        logic       swap_red_blue;
    } remap_cfg_t;

endpackage

@@ rtl/prrs_if.sv @@
// ----------------------------------------------------------------------------
// prrs_if
// Valid/ready channels of the palette remap row scaler.
// ----------------------------------------------------------------------------
interface prrs_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [7:0]  palette_slot;
    logic [31:0] palette_word;
    logic [7:0]  texel;
    logic        row_start;

    modport source (output valid, command, palette_slot, palette_word, texel, row_start,
                    input ready);
    modport sink   (input valid, command, palette_slot, palette_word, texel, row_start,
                    output ready);
endinterface

interface prrs_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_index;
    logic [31:0] out_color;
    logic [31:0] glow_color;
    logic [8:0]  out_column;
    logic        row_last;

    modport source (output valid, out_index, out_color, glow_color, out_column, row_last,
                    input ready);
    modport sink   (input valid, out_index, out_color, glow_color, out_column, row_last,
                    output ready);
endinterface

interface prrs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/prrs_ram.sv @@
// ----------------------------------------------------------------------------
// prrs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module prrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/prrs_remap.sv @@
// ----------------------------------------------------------------------------
// prrs_remap
// Player colour remap: rewrites the top and bottom 16-entry ranges.
// ----------------------------------------------------------------------------
module prrs_remap #(
    parameter int TOP_START    = prrs_pkg::TOP_START_DEF,
    parameter int BOTTOM_START = prrs_pkg::BOTTOM_START_DEF
) (
    input  prrs_pkg::remap_cfg_t cfg,
    input  logic [7:0]           texel,
    output logic [7:0]           index
);
    import prrs_pkg::*;

    localparam logic [8:0] TOP_LO = 9'(TOP_START);
    localparam logic [8:0] TOP_HI = 9'(TOP_START + RANGE_LEN);
    localparam logic [8:0] BOT_LO = 9'(BOTTOM_START);
    localparam logic [8:0] BOT_HI = 9'(BOTTOM_START + RANGE_LEN);

    // one entry of a range: clamp, optional swap, ascending or descending
    function automatic logic [7:0] range_entry(input logic [3:0] choice,
                                               input logic       swap,
                                               input logic [3:0] off);
        logic [3:0] c;
        logic [7:0] base;
        c = (choice > CHOICE_MAX) ? CHOICE_MAX : choice;
        if (swap)
        begin
            if (c == CHOICE_SWAP)
                c = CHOICE_MAX;
            else if (c == CHOICE_MAX)
                c = CHOICE_SWAP;
        end
        base = {c, 4'b0000};
        // base has a clear low nibble, so base+i and base+15-i are ORs
        return (base < RANGE_FLIP) ? (base | {4'b0000, off}) : (base | {4'b0000, ~off});
    endfunction

    logic [8:0] t_ext;
    logic [3:0] top_off;
    logic [3:0] bot_off;

    assign t_ext   = {1'b0, texel};
    assign top_off = 4'(texel - TOP_LO[7:0]);
    assign bot_off = 4'(texel - BOT_LO[7:0]);

    // bottom range wins where the two overlap
    always_comb
    begin
        if (t_ext >= BOT_LO && t_ext < BOT_HI)
            index = range_entry(cfg.bottom_color, cfg.swap_red_blue, bot_off);
        else if (t_ext >= TOP_LO && t_ext < TOP_HI)
            index = range_entry(cfg.top_color, cfg.swap_red_blue, top_off);
        else
            index = texel;
    end

endmodule

@@ rtl/palette_remap_row_scaler.sv @@
// ----------------------------------------------------------------------------
// palette_remap_row_scaler
// Remaps a row of texels, looks up the palette and scales horizontally.
// ----------------------------------------------------------------------------
// Usage:
//   src carries requests: command 0 writes palette_word into palette_slot,
//   command 1 delivers one texel; row_start on a texel restarts the row.
//   dst carries output pixels (index, colour, glow colour, column, last flag).
//   cfg writes the five settings by index; it is always ready and must only
//   be used while the block is idle.
// Texel flow:
//   For a texel the palette read comes first; then the single step loop
//   gives one pixel per cycle while dst is ready; the next request is taken
//   in the cycle that closes the texel. The first pixel passes the palette
//   read register and then the output register before it appears on dst.
// Reset:
//   Settings return to their defaults and the step and column counters
//   clear; palette contents stay undefined until written.
// Stalls:
//   A held output pixel stops the step loop; src is not accepted meanwhile.
// ----------------------------------------------------------------------------
module palette_remap_row_scaler #(
    parameter int TOP_START    = prrs_pkg::TOP_START_DEF,
    parameter int BOTTOM_START = prrs_pkg::BOTTOM_START_DEF,
    parameter int MAX_WIDTH    = prrs_pkg::MAX_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    prrs_cfg_if.sink    cfg,
    prrs_in_if.sink     src,
    prrs_out_if.source  dst
);
    import prrs_pkg::*;

    localparam int WCAP = (MAX_WIDTH > 1023) ? 1023 : MAX_WIDTH;
    localparam logic [COL_W-1:0] WIDTH_CAP = COL_W'(WCAP);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    // settings
    logic [3:0]        top_color_reg;
    logic [3:0]        bottom_color_reg;
    logic              swap_reg;
    logic [COL_W-1:0]  dest_width_reg;
    logic [STEP_W-1:0] frac_step_reg;

    // control and step state
    logic              state_reg,   state_next;
    logic [POS_W-1:0]  pos_reg,     pos_next;
    logic [COL_W-1:0]  src_col_reg, src_col_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [3:0]        burst_reg,   burst_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  texel_reg;

    // output register
    logic               dst_valid_reg, dst_valid_next;
    logic [IDX_W-1:0]   dst_index_reg;
    logic [COLOR_W-1:0] dst_color_reg;
    logic [COLOR_W-1:0] dst_glow_reg;
    logic [OCOL_W-1:0]  dst_col_reg;
    logic               dst_last_reg;

    remap_cfg_t         remap_cfg;
    logic [IDX_W-1:0]   remap_idx;
    logic [COLOR_W-1:0] pal_rdata;
    logic [COL_W-1:0]   width_eff;
    logic [STEP_W-1:0]  step_eff;
    logic [POS_W:0]     pos_sum;
    logic               emit_go;
    logic               load_out;
    logic               finish;
    logic               src_ready;
    logic               src_fire;
    logic               pal_we;
    logic               texel_fire;

    // settings write port
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_color_reg    <= 4'd0;
            bottom_color_reg <= 4'd0;
            swap_reg         <= 1'b0;
            dest_width_reg   <= 10'd512;
            frac_step_reg    <= 24'd37888;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_TOP_COLOR:    top_color_reg    <= cfg.data[3:0];
                REG_BOTTOM_COLOR: bottom_color_reg <= cfg.data[3:0];
                REG_SWAP:         swap_reg         <= cfg.data[0];
                REG_DEST_WIDTH:   dest_width_reg   <= cfg.data[COL_W-1:0];
                REG_FRAC_STEP:    frac_step_reg    <= cfg.data[STEP_W-1:0];
                default:          ;
            endcase
        end
    end

    // effective width and step
    assign width_eff = (dest_width_reg == '0) ? COL_W'(1) :
                       (dest_width_reg > WIDTH_CAP) ? WIDTH_CAP : dest_width_reg;
    assign step_eff  = (frac_step_reg < MIN_STEP) ? MIN_STEP : frac_step_reg;

    // remap of the incoming texel
    assign remap_cfg.top_color     = top_color_reg;
    assign remap_cfg.bottom_color  = bottom_color_reg;
    assign remap_cfg.swap_red_blue = swap_reg;

    prrs_remap #(
        .TOP_START    (TOP_START),
        .BOTTOM_START (BOTTOM_START)
    ) u_remap (
        .cfg   (remap_cfg),
        .texel (src.texel),
        .index (remap_idx)
    );

    // step loop condition
    assign emit_go  = (state_reg == ST_EMIT) && (burst_reg < MAX_BURST) &&
                      (out_col_reg < width_eff) && (pos_reg[POS_W-1:16] == src_col_reg);
    assign load_out = emit_go && (!dst_valid_reg || dst.ready);
    assign finish   = (state_reg == ST_EMIT) && !emit_go;

    // request handshake
    assign src_ready  = (state_reg == ST_IDLE) || finish;
    assign src.ready  = src_ready;
    assign src_fire   = src.valid && src_ready;
    assign pal_we     = src_fire && (src.command == CMD_PAL_WRITE);
    assign texel_fire = src_fire && (src.command == CMD_TEXEL);

    // palette store
    prrs_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PAL_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (pal_we),
        .waddr (src.palette_slot),
        .wdata (src.palette_word),
        .re    (texel_fire),
        .raddr (remap_idx),
        .rdata (pal_rdata)
    );

    assign pos_sum = {1'b0, pos_reg} + (POS_W+1)'(step_eff);

    // next state of the stepper
    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        src_col_next = src_col_reg;
        out_col_next = out_col_reg;
        burst_next   = burst_reg;

        if (load_out)
        begin
            burst_next = burst_reg + 4'd1;
            if (pos_sum[POS_W])
            begin
                pos_next     = '1;
                out_col_next = width_eff;
            end
            else
            begin
                pos_next     = pos_sum[POS_W-1:0];
                out_col_next = out_col_reg + COL_W'(1);
            end
        end

        if (finish)
        begin
            state_next = ST_IDLE;
            if (src_col_reg < COL_MAX)
                src_col_next = src_col_reg + COL_W'(1);
        end

        if (texel_fire)
        begin
            state_next = ST_EMIT;
            burst_next = 4'd0;
            if (src.row_start)
            begin
                pos_next     = POS_W'(frac_step_reg >> 1);
                src_col_next = '0;
                out_col_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            src_col_reg <= '0;
            out_col_reg <= '0;
            burst_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            src_col_reg <= src_col_next;
            out_col_reg <= out_col_next;
            burst_reg   <= burst_next;
        end
    end

    // per-texel payload
    always_ff @(posedge clk)
    begin
        if (texel_fire)
        begin
            idx_reg   <= remap_idx;
            texel_reg <= src.texel;
        end
    end

    // output register
    assign dst_valid_next = load_out || (dst_valid_reg && !dst.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dst_valid_reg <= 1'b0;
        else
            dst_valid_reg <= dst_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            dst_index_reg <= idx_reg;
            dst_color_reg <= pal_rdata;
            dst_glow_reg  <= (texel_reg < FULLBRIGHT) ? (pal_rdata & GLOW_MASK) : pal_rdata;
            dst_col_reg   <= out_col_reg[OCOL_W-1:0];
            dst_last_reg  <= ({1'b0, out_col_reg} + 11'd1) == {1'b0, width_eff};
        end
    end

    assign dst.valid      = dst_valid_reg;
    assign dst.out_index  = dst_index_reg;
    assign dst.out_color  = dst_color_reg;
    assign dst.glow_color = dst_glow_reg;
    assign dst.out_column = dst_col_reg;
    assign dst.row_last   = dst_last_reg;

`ifndef SYNTHESIS
    // a texel always leads into the step loop
    a_texel_enters_loop: assert property (@(posedge clk) disable iff (!rst_n)
        texel_fire |=> (state_reg == ST_EMIT))
        else $error("texel request did not start the step loop");

    // no more than eight pixels per texel
    a_burst_bound: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (burst_reg < MAX_BURST))
        else $error("burst limit exceeded");

    // a pending output is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid_reg && !dst.ready) |-> !load_out)
        else $error("held output pixel overwritten");

    // no request is taken while pixels are still being stepped out
    a_no_accept_in_loop: assert property (@(posedge clk) disable iff (!rst_n)
        emit_go |-> !src_ready)
        else $error("request accepted during step loop");
`endif

endmodule

@@ test/prrs_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// prrs_tb_pkg
// Pixel scoreboard for the palette remap row scaler testbench: it keeps its
// own palette, remap settings and step/column counters, works out the pixels
// that each accepted request must produce and checks the pixels that leave.
// ----------------------------------------------------------------------------
package prrs_tb_pkg;

    import prrs_pkg::*;

    // One output pixel as seen on dst
    typedef struct packed {
        logic [IDX_W-1:0]   index;
        logic [COLOR_W-1:0] color;
        logic [COLOR_W-1:0] glow;
        logic [OCOL_W-1:0]  column;
        logic               last;
    } pixel_t;

    class pixel_scoreboard;

        localparam logic [26:0] POS_LIMIT = 27'h3FF_FFFF;
        localparam int          PRINT_CAP = 50;

        pixel_t             pixel_q[$];
        logic [COLOR_W-1:0] pal_mem [PAL_DEPTH];
        logic [POS_W-1:0]   position;
        logic [COL_W-1:0]   src_col;
        logic [COL_W-1:0]   out_col;
        logic [3:0]         top_c;
        logic [3:0]         bottom_c;
        logic               swap_rb;
        logic [COL_W-1:0]   width_reg;
        logic [STEP_W-1:0]  step_reg;
        int                 top_start;
        int                 bottom_start;
        int                 max_width;
        int                 errors;

        function new(int ts, int bs, int mw);
            top_start    = ts;
            bottom_start = bs;
            max_width    = mw;
            errors       = 0;
            position     = '0;
            src_col      = '0;
            out_col      = '0;
            top_c        = 4'd0;
            bottom_c     = 4'd0;
            swap_rb      = 1'b0;
            width_reg    = 10'd512;
            step_reg     = 24'd37888;
            foreach (pal_mem[i]) pal_mem[i] = '0;
        endfunction

        // Print one line per mismatch (capped), always count it
        task report_mismatch(string msg);
            errors++;
            if (errors <= PRINT_CAP)
                $display("mismatch: %s", msg);
        endtask

        function int pending();
            return pixel_q.size();
        endfunction

        // Colour choice -> range base, with clamp and optional 4/13 swap
        function logic [7:0] choice_base(logic [3:0] c);
            logic [3:0] k;
            k = (c > CHOICE_MAX) ? CHOICE_MAX : c;
            if (swap_rb) begin
                if (k == CHOICE_SWAP)
                    k = CHOICE_MAX;
                else if (k == CHOICE_MAX)
                    k = CHOICE_SWAP;
            end
            return {k, 4'b0000};
        endfunction

        // Low bases run ascending, high bases descending
        function logic [7:0] range_entry(logic [7:0] base, logic [3:0] i);
            return (base < RANGE_FLIP) ? base + 8'(i) : base + 8'd15 - 8'(i);
        endfunction

        // Bottom range is tested first so it wins on overlap
        function logic [7:0] remap_index(logic [7:0] t);
            int ti;
            ti = t;
            if (ti >= bottom_start && ti < bottom_start + RANGE_LEN)
                return range_entry(choice_base(bottom_c), 4'(ti - bottom_start));
            if (ti >= top_start && ti < top_start + RANGE_LEN)
                return range_entry(choice_base(top_c), 4'(ti - top_start));
            return t;
        endfunction

        function void note_config(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
            case (idx)
                REG_TOP_COLOR:    top_c     = data[3:0];
                REG_BOTTOM_COLOR: bottom_c  = data[3:0];
                REG_SWAP:         swap_rb   = data[0];
                REG_DEST_WIDTH:   width_reg = data[COL_W-1:0];
                REG_FRAC_STEP:    step_reg  = data[STEP_W-1:0];
                default: ;
            endcase
        endfunction

        // Accepted request: update state and queue the pixels it must produce
        function void note_request(logic cmd, logic [7:0] slot, logic [31:0] word,
                                   logic [7:0] texel, logic row_start);
            int                w;
            logic [STEP_W-1:0] stp;
            logic [26:0]       nxt;
            logic [7:0]        idx;
            logic [31:0]       color;
            int                n;
            pixel_t            px;

            if (cmd == CMD_PAL_WRITE) begin
                pal_mem[slot] = word;
                return;
            end

            stp = (step_reg < MIN_STEP) ? MIN_STEP : step_reg;
            w = width_reg;
            if (w < 1)
                w = 1;
            if (w > max_width)
                w = max_width;
            if (w > int'(COL_MAX))
                w = COL_MAX;

            // Row restart takes half of the raw step register
            if (row_start) begin
                position = POS_W'(step_reg >> 1);
                src_col  = '0;
                out_col  = '0;
            end

            idx   = remap_index(texel);
            color = pal_mem[idx];
            n     = 0;
            while (n < int'(MAX_BURST) && int'(out_col) < w && position[25:16] == src_col) begin
                px.index  = idx;
                px.color  = color;
                px.glow   = (texel < FULLBRIGHT) ? (color & GLOW_MASK) : color;
                px.column = out_col[OCOL_W-1:0];
                px.last   = (int'(out_col) + 1 == w);
                pixel_q.push_back(px);
                n++;
                out_col++;
                nxt = 27'(position) + 27'(stp);
                // Overflow pins the position and ends the row silently
                if (nxt > POS_LIMIT) begin
                    position = '1;
                    out_col  = COL_W'(w);
                end
                else begin
                    position = nxt[POS_W-1:0];
                end
            end

            if (src_col < COL_MAX)
                src_col++;
        endfunction

        // Compare one output pixel with the oldest expectation
        task check_result(pixel_t got);
            pixel_t want;
            if (pixel_q.size() == 0) begin
                report_mismatch($sformatf("unexpected pixel idx=%0h col=%0d",
                                          got.index, got.column));
                return;
            end
            want = pixel_q.pop_front();
            if (got.index !== want.index)
                report_mismatch($sformatf("out_index %0h, want %0h", got.index, want.index));
            if (got.color !== want.color)
                report_mismatch($sformatf("out_color %h, want %h", got.color, want.color));
            if (got.glow !== want.glow)
                report_mismatch($sformatf("glow_color %h, want %h", got.glow, want.glow));
            if (got.column !== want.column)
                report_mismatch($sformatf("out_column %0d, want %0d", got.column, want.column));
            if (got.last !== want.last)
                report_mismatch($sformatf("row_last %b, want %b at column %0d",
                                          got.last, want.last, want.column));
        endtask

        task finish_check();
            if (pixel_q.size() != 0)
                report_mismatch($sformatf("%0d pixels never arrived", pixel_q.size()));
        endtask

    endclass

endpackage

@@ test/tb_palette_remap_row_scaler.sv @@
// ----------------------------------------------------------------------------
// tb_palette_remap_row_scaler
// Drives palette writes and texel rows into the scaler under changing remap
// and scale settings and idle patterns, and checks every output pixel
// against the scoreboard's own prediction.
// ----------------------------------------------------------------------------
module tb_palette_remap_row_scaler;

    import prrs_pkg::*;
    import prrs_tb_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 40;
    localparam int RANDOM_PHASES = 4;
    localparam int ROW_SPAN_MAX  = 12;
    localparam int SETTLE_CYCLES = 4;

    logic clk;
    logic rst_n;

    prrs_cfg_if cfg_ch ();
    prrs_in_if  src_ch ();
    prrs_out_if dst_ch ();

    palette_remap_row_scaler i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .src   (src_ch),
        .dst   (dst_ch)
    );

    pixel_scoreboard sb;
    int              sender_idle_pct;
    int              receiver_stall_pct;
    int              random_count;
    int              cycle_count;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // Receiver back-pressure
    always @(posedge clk)
    begin
        dst_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Handshake monitor: config and requests first, then pixels
    always @(posedge clk)
    begin : monitor
        pixel_t got;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                sb.note_config(cfg_ch.index, cfg_ch.data);
            if (src_ch.valid && src_ch.ready)
                sb.note_request(src_ch.command, src_ch.palette_slot, src_ch.palette_word,
                                src_ch.texel, src_ch.row_start);
            if (dst_ch.valid && dst_ch.ready)
            begin
                got.index  = dst_ch.out_index;
                got.color  = dst_ch.out_color;
                got.glow   = dst_ch.glow_color;
                got.column = dst_ch.out_column;
                got.last   = dst_ch.row_last;
                sb.check_result(got);
            end
        end
    end

    // 0: no idling, 1: sender idle, 2: receiver stalls, 3: both lightly
    task automatic set_idle(int mode);
        case (mode % 4)
            0:
            begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
            1:
            begin
                sender_idle_pct    = 82;
                receiver_stall_pct = 0;
            end
            2:
            begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 82;
            end
            default:
            begin
                sender_idle_pct    = 7;
                receiver_stall_pct = 7;
            end
        endcase
    endtask

    // One request on src, held until accepted
    task automatic send_req(logic cmd, logic [7:0] slot, logic [31:0] word,
                            logic [7:0] tx, logic rs);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            src_ch.valid <= 1'b0;
            @(posedge clk);
        end
        src_ch.valid        <= 1'b1;
        src_ch.command      <= cmd;
        src_ch.palette_slot <= slot;
        src_ch.palette_word <= word;
        src_ch.texel        <= tx;
        src_ch.row_start    <= rs;
        do
            @(posedge clk);
        while (!src_ch.ready);
    endtask

    task automatic send_texel(logic [7:0] tx, logic rs);
        send_req(CMD_TEXEL, 8'($urandom), $urandom, tx, rs);
    endtask

    task automatic send_palette(logic [7:0] slot, logic [31:0] word);
        send_req(CMD_PAL_WRITE, slot, word, 8'($urandom), 1'($urandom));
    endtask

    // Hold off until every expected pixel is out, then let the block finish
    task automatic settle();
        src_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
        settle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic apply_setting(logic [3:0] top, logic [3:0] bottom, logic swap,
                                 logic [9:0] width, logic [23:0] step);
        cfg_write(REG_TOP_COLOR, CFG_DW'(top));
        cfg_write(REG_BOTTOM_COLOR, CFG_DW'(bottom));
        cfg_write(REG_SWAP, CFG_DW'(swap));
        cfg_write(REG_DEST_WIDTH, CFG_DW'(width));
        cfg_write(REG_FRAC_STEP, step);
    endtask

    // Texels biased toward the remap ranges and the fullbright end
    function automatic logic [7:0] pick_texel();
        case ($urandom_range(4))
            0:       return 8'(TOP_START_DEF + $urandom_range(RANGE_LEN - 1));
            1:       return 8'(BOTTOM_START_DEF + $urandom_range(RANGE_LEN - 1));
            2:       return 8'(int'(FULLBRIGHT) + $urandom_range(31));
            3:       return 8'(int'(FULLBRIGHT) - 1 - $urandom_range(7));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // A row of texels with palette writes mixed in now and then
    task automatic send_row(int len, bit with_start, bit pause_inside);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < 8)
            begin
                send_palette(8'($urandom), $urandom);
                random_count++;
            end
            if (pause_inside && i == len / 2)
                settle();
            send_texel(pick_texel(), with_start && i == 0);
            random_count++;
        end
    endtask

    // Random setting, mostly narrow rows
    task automatic random_setting(output int w_eff, output int s_eff);
        logic [9:0]  width;
        logic [23:0] step;
        case ($urandom_range(9))
            0:       width = 10'd512;
            1:       width = 10'($urandom_range(513, 1023));
            2:       width = 10'($urandom_range(1023));
            3:       width = 10'd0;
            default: width = 10'($urandom_range(1, 24));
        endcase
        case ($urandom_range(9))
            0, 1:    step = 24'($urandom_range(8191));
            2:       step = 24'($urandom_range(32'h2_0000, 32'h80_0000));
            3:       step = 24'($urandom_range(32'h80_0001, 32'hFF_FFFF));
            default: step = 24'($urandom_range(32'h4000, 32'h2_0000));
        endcase
        apply_setting(4'($urandom), 4'($urandom), 1'($urandom), width, step);
        w_eff = (width == 0) ? 1 : ((width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width);
        s_eff = (step < MIN_STEP) ? MIN_STEP : step;
    endtask

    initial
    begin : main
        int     w_eff;
        int     s_eff;
        int     phase;
        int     rows;
        longint span;

        sb = new(TOP_START_DEF, BOTTOM_START_DEF, MAX_WIDTH_DEF);
        random_count = 0;
        set_idle(0);
        rst_n               <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= '0;
        cfg_ch.data         <= '0;
        src_ch.valid        <= 1'b0;
        src_ch.command      <= CMD_PAL_WRITE;
        src_ch.palette_slot <= '0;
        src_ch.palette_word <= '0;
        src_ch.texel        <= '0;
        src_ch.row_start    <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the whole palette so no texel reads an unwritten entry
        for (int s = 0; s < PAL_DEPTH; s++)
            send_palette(8'(s), (s == 0) ? 32'h0 : ((s == 255) ? 32'hFFFF_FFFF : $urandom));

        // Reset settings: plain, both ranges, fullbright boundary
        send_texel(8'd0, 1'b1);
        send_texel(8'd255, 1'b0);
        send_texel(8'd16, 1'b0);
        send_texel(8'd31, 1'b0);
        send_texel(8'd96, 1'b0);
        send_texel(8'd111, 1'b0);
        send_texel(8'd224, 1'b0);
        send_texel(8'd223, 1'b0);

        // Clamped top, swapped bottom, width above max, step below minimum
        apply_setting(4'd15, CHOICE_SWAP, 1'b1, 10'd1023, 24'd0);
        send_texel(8'd20, 1'b1);
        send_texel(8'd100, 1'b0);
        send_texel(8'd110, 1'b0);

        // Width zero acts as one; continuation without row start
        apply_setting(CHOICE_MAX, CHOICE_MAX, 1'b1, 10'd0, 24'h01_0000);
        send_texel(8'd17, 1'b1);
        send_texel(8'd97, 1'b0);
        send_texel(8'd230, 1'b0);
        send_texel(8'd99, 1'b1);

        // Ascending and descending ranges, skipped columns
        apply_setting(4'd7, 4'd8, 1'b0, 10'd4, 24'h03_0000);
        send_texel(8'd16, 1'b1);
        send_texel(8'd31, 1'b0);
        send_texel(8'd96, 1'b0);
        send_texel(8'd111, 1'b0);
        send_texel(8'd240, 1'b0);

        // Random phases of settings and rows, every idle pattern at least once
        phase = 0;
        while (random_count < RANDOM_ITEMS || phase < RANDOM_PHASES)
        begin
            set_idle(0);
            random_setting(w_eff, s_eff);
            set_idle(phase);
            rows = $urandom_range(1, 3);
            for (int r = 0; r < rows; r++)
            begin
                span = (longint'(w_eff) * s_eff) / 65536 + 3;
                if (span > ROW_SPAN_MAX)
                    span = ROW_SPAN_MAX;
                send_row($urandom_range(1, int'(span)), $urandom_range(9) != 0,
                         phase == 1 || $urandom_range(9) < 2);
            end
            phase++;
        end

        // Back to defaults at the end of the run
        apply_setting(4'd0, 4'd0, 1'b0, 10'd512, 24'd37888);
        set_idle(2);
        send_row(12, 1'b1, 1'b0);

        settle();
        repeat (16) @(posedge clk);
        sb.finish_check();
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/prrs_pkg.sv
rtl/prrs_if.sv
rtl/prrs_ram.sv
rtl/prrs_remap.sv
rtl/palette_remap_row_scaler.sv
test/prrs_tb_pkg.sv
test/tb_palette_remap_row_scaler.sv
